### rtl/pwb_pkg.sv
`timescale 1ns / 1ps
package pwb_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int SUB_STEPS     = 2;
   localparam int FT_W          = 16;
   localparam int DT_W          = 15;
   localparam int DEN_W         = 21;
   localparam int R_W           = 23;
   localparam int WORLD_W       = 31;
   localparam int IDX_W         = 3;
   localparam int HIT_W         = 4;
   localparam int QUEUE_DEPTH   = 8;
   localparam int QPTR_W        = 3;
   localparam int FRONT_DEPTH   = 5;
   localparam int BUSY_LEVEL    = QUEUE_DEPTH - FRONT_DEPTH;

   localparam logic signed [63:0] S32_MAX64 = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN64 = -64'sd2147483648;

   typedef enum logic [IDX_W-1:0] {
      REG_GRAV_EN  = 3'd0,
      REG_GRAV_X   = 3'd1,
      REG_GRAV_Y   = 3'd2,
      REG_WORLD_W  = 3'd3,
      REG_WORLD_H  = 3'd4,
      REG_TOP_EN   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                     grav_en;
      logic signed [31:0]       grav_x;
      logic signed [31:0]       grav_y;
      logic [WORLD_W-1:0]       world_w;
      logic [WORLD_W-1:0]       world_h;
      logic                     top_en;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic [R_W-1:0]     radius;
      logic [DEN_W-1:0]   den;
   } work_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > S32_MAX64) begin
         return 32'h7FFFFFFF;
      end else if (v < S32_MIN64) begin
         return 32'h80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      if (v == 32'sh80000000) begin
         return 32'h7FFFFFFF;
      end else begin
         return -v;
      end
   endfunction

endpackage

### rtl/particle_integrate_wall_bounce.sv
`timescale 1ns / 1ps
// channel   ports                             handshake
// -------   -------------------------------   ---------------------------------
// request   req_pos_x .. req_frame_time       start high and busy low at edge
// result    rsp_new_pos_x .. rsp_wall_hit     rsp_valid for one cycle
// csr       csr_index, csr_wr_data            csr_wr_en high at edge
//
// One item per cycle while busy is low; each item passes through, in order,
// five front stages, two queue stages, two restoring dividers of
// 32 + FRAC_BITS stages side by side, and two wall stages. Reset is synchronous
// and loads the register defaults. The receiver cannot stall, so the queue
// drains every cycle and busy only rises if the queue were ever to back up.
module particle_integrate_wall_bounce #(
   parameter int FRAC_BITS = pwb_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [31:0]            req_pos_x,
   input  logic signed [31:0]            req_pos_y,
   input  logic signed [31:0]            req_vel_x,
   input  logic signed [31:0]            req_vel_y,
   input  logic signed [31:0]            req_acc_x,
   input  logic signed [31:0]            req_acc_y,
   input  logic [pwb_pkg::R_W-1:0]       req_radius,
   input  logic [pwb_pkg::FT_W-1:0]      req_frame_time,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_new_pos_x,
   output logic signed [31:0]            rsp_new_pos_y,
   output logic signed [31:0]            rsp_new_vel_x,
   output logic signed [31:0]            rsp_new_vel_y,
   output logic [pwb_pkg::HIT_W-1:0]     rsp_wall_hit,
   input  logic                          csr_wr_en,
   input  logic [pwb_pkg::IDX_W-1:0]     csr_index,
   input  logic [31:0]                   csr_wr_data
);
   import pwb_pkg::*;

   cfg_type         cfg_ff;
   logic            accept;
   logic            f_valid, q_valid;
   work_type        f_item, q_item;
   logic [QPTR_W:0] q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grav_en <= 1'b1;
         cfg_ff.grav_x  <= 32'sd0;
         cfg_ff.grav_y  <= 32'sd642908;
         cfg_ff.world_w <= WORLD_W'(12582912);
         cfg_ff.world_h <= WORLD_W'(7077888);
         cfg_ff.top_en  <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRAV_EN: cfg_ff.grav_en <= csr_wr_data[0];
            REG_GRAV_X:  cfg_ff.grav_x  <= csr_wr_data;
            REG_GRAV_Y:  cfg_ff.grav_y  <= csr_wr_data;
            REG_WORLD_W: cfg_ff.world_w <= csr_wr_data[WORLD_W-1:0];
            REG_WORLD_H: cfg_ff.world_h <= csr_wr_data[WORLD_W-1:0];
            REG_TOP_EN:  cfg_ff.top_en  <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   assign busy   = (q_count >= (QPTR_W+1)'(BUSY_LEVEL));
   assign accept = start && !busy;

   pwb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .vel_x     (req_vel_x),
      .vel_y     (req_vel_y),
      .acc_x     (req_acc_x),
      .acc_y     (req_acc_y),
      .radius    (req_radius),
      .frame_time(req_frame_time),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_item  (f_item)
   );

   pwb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .push_item(f_item),
      .pop_valid(q_valid),
      .pop_item (q_item),
      .count    (q_count)
   );

   pwb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_valid),
      .in_item      (q_item),
      .cfg          (cfg_ff),
      .rsp_valid    (rsp_valid),
      .rsp_new_pos_x(rsp_new_pos_x),
      .rsp_new_pos_y(rsp_new_pos_y),
      .rsp_new_vel_x(rsp_new_vel_x),
      .rsp_new_vel_y(rsp_new_vel_y),
      .rsp_wall_hit (rsp_wall_hit)
   );

   a_front_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(FRONT_DEPTH) f_valid)
      else $error("front lost an item");
   a_front_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(f_valid) |-> $past(accept, FRONT_DEPTH))
      else $error("front item without request");
   a_queue_to_back: assert property (@(posedge clock) disable iff (reset)
      f_valid |=> ##1 q_valid)
      else $error("queued item not delivered");

endmodule

### rtl/pwb_front.sv
`timescale 1ns / 1ps
module pwb_front #(
   parameter int FRAC_BITS = pwb_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [31:0]         pos_x,
   input  logic signed [31:0]         pos_y,
   input  logic signed [31:0]         vel_x,
   input  logic signed [31:0]         vel_y,
   input  logic signed [31:0]         acc_x,
   input  logic signed [31:0]         acc_y,
   input  logic [pwb_pkg::R_W-1:0]    radius,
   input  logic [pwb_pkg::FT_W-1:0]   frame_time,
   input  pwb_pkg::cfg_type           cfg,
   output logic                       out_valid,
   output pwb_pkg::work_type          out_item
);
   import pwb_pkg::*;

   localparam logic signed [63:0] ROUND_ADJ = (64'sd1 <<< FRAC_BITS) - 64'sd1;

   function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p[63] ? p + ROUND_ADJ : p;
      return t >>> FRAC_BITS;
   endfunction

   logic [FT_W-1:0]  half;
   logic [DT_W-1:0]  dt_in;

   logic             v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   work_type         it0_ff, it1_ff, it2_ff, it3_ff, it4_ff;
   logic [DT_W-1:0]  dt0_ff, dt1_ff, dt2_ff;
   logic signed [31:0] ax0_ff, ay0_ff, ax1_ff, ay1_ff, ax2_ff, ay2_ff;
   logic signed [47:0] gx_in, gy_in, gx1_ff, gy1_ff;
   logic signed [47:0] px_in, py_in, px3_ff, py3_ff;

   // dt = frame_time / 2, never below one LSB
   assign half  = FT_W'(frame_time / SUB_STEPS);
   assign dt_in = (half == '0) ? DT_W'(1) : half[DT_W-1:0];

   assign gx_in = cfg.grav_x * $signed({1'b0, dt0_ff});
   assign gy_in = cfg.grav_y * $signed({1'b0, dt0_ff});
   assign px_in = ax2_ff * $signed({1'b0, dt2_ff});
   assign py_in = ay2_ff * $signed({1'b0, dt2_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      it0_ff.pos_x     <= pos_x;
      it0_ff.pos_y     <= pos_y;
      it0_ff.vel_x     <= vel_x;
      it0_ff.vel_y     <= vel_y;
      it0_ff.new_vel_x <= vel_x;
      it0_ff.new_vel_y <= vel_y;
      it0_ff.radius    <= radius;
      it0_ff.den       <= DEN_W'({6'd0, dt_in} * 21'd60);
      dt0_ff           <= dt_in;
      ax0_ff           <= acc_x;
      ay0_ff           <= acc_y;

      it1_ff <= it0_ff;
      dt1_ff <= dt0_ff;
      ax1_ff <= ax0_ff;
      ay1_ff <= ay0_ff;
      gx1_ff <= gx_in;
      gy1_ff <= gy_in;

      it2_ff <= it1_ff;
      dt2_ff <= dt1_ff;
      ax2_ff <= cfg.grav_en ? sat32(64'(ax1_ff) + shr_trunc(64'(gx1_ff))) : ax1_ff;
      ay2_ff <= cfg.grav_en ? sat32(64'(ay1_ff) + shr_trunc(64'(gy1_ff))) : ay1_ff;

      it3_ff <= it2_ff;
      px3_ff <= px_in;
      py3_ff <= py_in;

      it4_ff.pos_x     <= it3_ff.pos_x;
      it4_ff.pos_y     <= it3_ff.pos_y;
      it4_ff.vel_x     <= it3_ff.vel_x;
      it4_ff.vel_y     <= it3_ff.vel_y;
      it4_ff.radius    <= it3_ff.radius;
      it4_ff.den       <= it3_ff.den;
      it4_ff.new_vel_x <= sat32(64'(it3_ff.vel_x) + shr_trunc(64'(px3_ff)));
      it4_ff.new_vel_y <= sat32(64'(it3_ff.vel_y) + shr_trunc(64'(py3_ff)));
   end

   assign out_valid = v4_ff;
   assign out_item  = it4_ff;

endmodule

### rtl/pwb_queue.sv
`timescale 1ns / 1ps
module pwb_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pwb_pkg::work_type        push_item,
   output logic                     pop_valid,
   output pwb_pkg::work_type        pop_item,
   output logic [pwb_pkg::QPTR_W:0] count
);
   import pwb_pkg::*;

   work_type          mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              pop;
   logic              pop_valid_ff;
   work_type          pop_item_ff;

   // the back end never stalls, so an item leaves as soon as one is held
   assign pop      = (count_ff != '0);
   assign count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff     <= count_in;
         pop_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
      pop_item_ff <= mem[rd_ptr_ff];
   end

   assign pop_valid = pop_valid_ff;
   assign pop_item  = pop_item_ff;
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == (QPTR_W+1)'(QUEUE_DEPTH)))
      else $error("queue overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost an item");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue underflow");

endmodule

### rtl/pwb_div.sv
`timescale 1ns / 1ps
module pwb_div #(
   parameter int NW = 48,
   parameter int DW = pwb_pkg::DEN_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic          in_neg,
   input  logic [NW-1:0] in_mag,
   input  logic [DW-1:0] in_den,
   output logic          out_valid,
   output logic          out_neg,
   output logic [NW-1:0] out_quo
);
   logic          vld [NW+1];
   logic          neg [NW+1];
   logic [NW-1:0] acc [NW+1];
   logic [DW-1:0] rem [NW+1];
   logic [DW-1:0] den [NW+1];

   assign vld[0] = in_valid;
   assign neg[0] = in_neg;
   assign acc[0] = in_mag;
   assign rem[0] = '0;
   assign den[0] = in_den;

   // one quotient bit per stage; quotient bits shift in behind the dividend
   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [DW:0]   r_sh;
      logic          ge;
      logic          vld_ff, neg_ff;
      logic [NW-1:0] acc_ff;
      logic [DW-1:0] rem_ff, den_ff;

      assign r_sh = {rem[i], acc[i][NW-1]};
      assign ge   = (r_sh >= {1'b0, den[i]});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld[i];
         end
      end

      always_ff @(posedge clock) begin
         neg_ff <= neg[i];
         den_ff <= den[i];
         acc_ff <= {acc[i][NW-2:0], ge};
         rem_ff <= ge ? DW'(r_sh - {1'b0, den[i]}) : r_sh[DW-1:0];
      end

      assign vld[i+1] = vld_ff;
      assign neg[i+1] = neg_ff;
      assign acc[i+1] = acc_ff;
      assign rem[i+1] = rem_ff;
      assign den[i+1] = den_ff;
   end

   assign out_valid = vld[NW];
   assign out_neg   = neg[NW];
   assign out_quo   = acc[NW];

endmodule

### rtl/pwb_back.sv
`timescale 1ns / 1ps
module pwb_back #(
   parameter int FRAC_BITS = pwb_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  pwb_pkg::work_type             in_item,
   input  pwb_pkg::cfg_type              cfg,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_new_pos_x,
   output logic signed [31:0]            rsp_new_pos_y,
   output logic signed [31:0]            rsp_new_vel_x,
   output logic signed [31:0]            rsp_new_vel_y,
   output logic [pwb_pkg::HIT_W-1:0]     rsp_wall_hit
);
   import pwb_pkg::*;

   localparam int NW = 32 + FRAC_BITS;
   localparam logic signed [33:0] TOP_OFF =
      34'(((64'sd1 <<< FRAC_BITS) + 64'sd50) / 64'sd100);

   logic [31:0]      mag_x, mag_y;
   logic             dvx_valid, dvy_valid, nx, ny;
   logic [NW-1:0]    qx, qy;
   work_type         dly_ff [NW];

   logic             v1_ff;
   logic signed [31:0] px1_ff, py1_ff, vx1_ff, vy1_ff;
   logic [R_W-1:0]   r1_ff;

   logic signed [31:0] dqx, dqy;
   logic signed [33:0] r_s, px_s, py_s, lim_r, lim_b, top_y, y1;
   logic             hit_l, hit_r, hit_t, hit_b;
   logic signed [31:0] vy_t;

   logic             out_v_ff;
   logic signed [31:0] opx_ff, opy_ff, ovx_ff, ovy_ff;
   logic [HIT_W-1:0] ohit_ff;

   assign mag_x = in_item.vel_x[31] ? 32'(-in_item.vel_x) : in_item.vel_x;
   assign mag_y = in_item.vel_y[31] ? 32'(-in_item.vel_y) : in_item.vel_y;

   pwb_div #(.NW(NW), .DW(DEN_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_neg   (in_item.vel_x[31]),
      .in_mag   ({mag_x, {FRAC_BITS{1'b0}}}),
      .in_den   (in_item.den),
      .out_valid(dvx_valid),
      .out_neg  (nx),
      .out_quo  (qx)
   );

   pwb_div #(.NW(NW), .DW(DEN_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_neg   (in_item.vel_y[31]),
      .in_mag   ({mag_y, {FRAC_BITS{1'b0}}}),
      .in_den   (in_item.den),
      .out_valid(dvy_valid),
      .out_neg  (ny),
      .out_quo  (qy)
   );

   always_ff @(posedge clock) begin
      dly_ff[0] <= in_item;
      for (int i = 1; i < NW; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
   end

   assign dqx = sat32(nx ? -$signed(64'(qx)) : $signed(64'(qx)));
   assign dqy = sat32(ny ? -$signed(64'(qy)) : $signed(64'(qy)));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= dvx_valid;
         out_v_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      px1_ff <= sat32(64'(dly_ff[NW-1].pos_x) + 64'(dqx));
      py1_ff <= sat32(64'(dly_ff[NW-1].pos_y) + 64'(dqy));
      vx1_ff <= dly_ff[NW-1].new_vel_x;
      vy1_ff <= dly_ff[NW-1].new_vel_y;
      r1_ff  <= dly_ff[NW-1].radius;
   end

   // walls: side first, then top, then bottom on the already clamped y
   assign r_s   = $signed({11'd0, r1_ff});
   assign px_s  = 34'(px1_ff);
   assign py_s  = 34'(py1_ff);
   assign lim_r = $signed({3'd0, cfg.world_w}) - r_s;
   assign lim_b = $signed({3'd0, cfg.world_h}) - r_s;
   assign top_y = r_s + TOP_OFF;
   assign hit_l = (px_s < r_s);
   assign hit_r = !hit_l && (px_s > lim_r);
   assign hit_t = cfg.top_en && (py_s < r_s);
   assign y1    = hit_t ? top_y : py_s;
   assign vy_t  = hit_t ? neg_sat(vy1_ff) : vy1_ff;
   assign hit_b = (y1 > lim_b);

   always_ff @(posedge clock) begin
      opx_ff  <= hit_l ? r_s[31:0] : (hit_r ? lim_r[31:0] : px1_ff);
      ovx_ff  <= (hit_l || hit_r) ? neg_sat(vx1_ff) : vx1_ff;
      opy_ff  <= hit_b ? lim_b[31:0] : y1[31:0];
      ovy_ff  <= hit_b ? neg_sat(vy_t) : vy_t;
      ohit_ff <= {hit_b, hit_t, hit_r, hit_l};
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_new_pos_x = opx_ff;
   assign rsp_new_pos_y = opy_ff;
   assign rsp_new_vel_x = ovx_ff;
   assign rsp_new_vel_y = ovy_ff;
   assign rsp_wall_hit  = ohit_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##(NW+2) rsp_valid)
      else $error("item lost in back end");
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid, NW+2))
      else $error("result without item");
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dvx_valid == dvy_valid)
      else $error("divider lanes out of step");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_wall_hit[0] && rsp_wall_hit[1]))
      else $error("both side walls hit");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import pwb_pkg::*;

   localparam int  LATENCY     = FRAC_BITS_DEF + 46;
   localparam int  CYCLE_LIMIT = 200000;
   localparam longint TOP_OFS  = 655;

   typedef struct {
      logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
      logic [R_W-1:0]     radius;
      logic [FT_W-1:0]    frame_time;
   } particle_t;

   typedef struct {
      logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
      logic [HIT_W-1:0]   hit;
   } step_result_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_vel_x = 0, req_vel_y = 0;
   logic signed [31:0] req_acc_x = 0, req_acc_y = 0;
   logic [R_W-1:0]     req_radius = 0;
   logic [FT_W-1:0]    req_frame_time = 0;
   logic               rsp_valid;
   logic signed [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_vel_x, rsp_new_vel_y;
   logic [HIT_W-1:0]   rsp_wall_hit;
   logic               csr_wr_en = 0;
   logic [IDX_W-1:0]   csr_index = 0;
   logic [31:0]        csr_wr_data = 0;

   // shadow of the block's registers
   bit     grav_en = 1;
   longint grav_x = 0, grav_y = 642908;
   longint world_w = 12582912, world_h = 7077888;
   bit     top_en = 1;

   step_result_t expected_steps[$];
   int     mismatches = 0;
   int     cycles = 0;
   bit     no_idle = 0;
   bit     driving = 0;

   particle_integrate_wall_bounce i_dut (.*);

   always #1 clock = ~clock;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic step_result_t integrate_step(particle_t p);
      longint px, py, vx, vy, ax, ay, r, dt, den;
      step_result_t o;
      px = p.pos_x; py = p.pos_y; vx = p.vel_x; vy = p.vel_y;
      ax = p.acc_x; ay = p.acc_y;
      r  = p.radius;
      dt = p.frame_time / 2;
      o.hit = 0;
      if (dt < 1) dt = 1;
      den = dt * 60;
      px = clamp32(px + clamp32((vx * 65536) / den));
      py = clamp32(py + clamp32((vy * 65536) / den));
      if (grav_en) begin
         ax = clamp32(ax + (grav_x * dt) / 65536);
         ay = clamp32(ay + (grav_y * dt) / 65536);
      end
      vx = clamp32(vx + (ax * dt) / 65536);
      vy = clamp32(vy + (ay * dt) / 65536);
      if (px < r) begin
         px = r; vx = clamp32(-vx); o.hit[0] = 1;
      end else if (px > world_w - r) begin
         px = world_w - r; vx = clamp32(-vx); o.hit[1] = 1;
      end
      if (top_en && py < r) begin
         py = r + TOP_OFS; vy = clamp32(-vy); o.hit[2] = 1;
      end
      if (py > world_h - r) begin
         py = world_h - r; vy = clamp32(-vy); o.hit[3] = 1;
      end
      o.pos_x = px[31:0]; o.pos_y = py[31:0];
      o.vel_x = vx[31:0]; o.vel_y = vy[31:0];
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      step_result_t e;
      if (!reset && rsp_valid) begin
         if (expected_steps.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            e = expected_steps.pop_front();
            if (e.pos_x !== rsp_new_pos_x || e.pos_y !== rsp_new_pos_y ||
                e.vel_x !== rsp_new_vel_x || e.vel_y !== rsp_new_vel_y ||
                e.hit !== rsp_wall_hit) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: exp pos %0d %0d vel %0d %0d hit %b, got %0d %0d %0d %0d %b",
                           e.pos_x, e.pos_y, e.vel_x, e.vel_y, e.hit, rsp_new_pos_x,
                           rsp_new_pos_y, rsp_new_vel_x, rsp_new_vel_y, rsp_wall_hit);
            end
         end
      end
   end

   task automatic send_item(particle_t p);
      int  gap;
      bit  taken;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0 && driving) begin
         start <= 0;
         driving = 0;
      end
      repeat (gap) @(posedge clock);
      start <= 1;
      driving = 1;
      req_pos_x <= p.pos_x; req_pos_y <= p.pos_y;
      req_vel_x <= p.vel_x; req_vel_y <= p.vel_y;
      req_acc_x <= p.acc_x; req_acc_y <= p.acc_y;
      req_radius <= p.radius; req_frame_time <= p.frame_time;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      expected_steps.push_back(integrate_step(p));
   endtask

   task automatic drain;
      if (driving) begin
         start <= 0;
         driving = 0;
      end
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1; csr_index <= idx; csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      case (idx)
         REG_GRAV_EN: grav_en = value[0];
         REG_GRAV_X:  grav_x = longint'(signed'(value));
         REG_GRAV_Y:  grav_y = longint'(signed'(value));
         REG_WORLD_W: world_w = value[30:0];
         REG_WORLD_H: world_h = value[30:0];
         REG_TOP_EN:  top_en = value[0];
         default: ;
      endcase
   endtask

   function automatic particle_t make_particle(longint px, longint py, longint vx,
                                               longint vy, longint ax, longint ay,
                                               longint r, longint ft);
      particle_t p;
      p.pos_x = px[31:0]; p.pos_y = py[31:0]; p.vel_x = vx[31:0]; p.vel_y = vy[31:0];
      p.acc_x = ax[31:0]; p.acc_y = ay[31:0];
      p.radius = r[R_W-1:0]; p.frame_time = ft[FT_W-1:0];
      return p;
   endfunction

   // mostly particles inside the world, some anywhere at all
   function automatic particle_t random_particle();
      particle_t p;
      if ($urandom_range(0, 3) == 0) begin
         p = make_particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
         if ($urandom_range(0, 1)) p.radius = $urandom_range(0, 4194304);
      end else begin
         p.radius = $urandom_range(0, 65536);
         p.pos_x = $urandom_range(0, world_w[30:0] + 65536);
         p.pos_y = $urandom_range(0, world_h[30:0] + 65536);
         p.vel_x = int'($urandom_range(0, 2000000)) - 1000000;
         p.vel_y = int'($urandom_range(0, 2000000)) - 1000000;
         p.acc_x = int'($urandom_range(0, 2000000)) - 1000000;
         p.acc_y = int'($urandom_range(0, 2000000)) - 1000000;
         p.frame_time = $urandom_range(2, 65535);
      end
      return p;
   endfunction

   task automatic test_directed;
      send_item(make_particle(0, 0, 0, 0, 0, 0, 0, 2));
      send_item(make_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 4194304, 65535));
      send_item(make_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000, 0, 65535));
      send_item(make_particle(100000, 100000, 1000, 1000, 0, 0, 1000, 0));
      send_item(make_particle(100000, 100000, -1000, -1000, 0, 0, 1000, 1));
      send_item(make_particle(6000000, 3000000, 65536, 65536, 65536, 65536, 65536, 3));
      send_item(make_particle(6000000, 100, 0, -65536, 0, 32'h80000000, 65536, 1092));
      send_item(make_particle(12582912, 7077888, 5000, 5000, 0, 0, 32768, 1092));
      send_item(make_particle(6000000, 3000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000, 0, 2));
      send_item(make_particle(6000000, 3000000, 0, 0, 0, 0, 8388607, 1092));
      send_item(make_particle(-100, -100, 300, 300, 0, 0, 4194304, 65534));
      drain();
      write_csr(REG_WORLD_H, 32'd100);
      write_csr(REG_GRAV_EN, 32'd0);
      send_item(make_particle(50, -50, 0, 0, 0, 0, 200, 1092));
      send_item(make_particle(32'h80000000, 0, 32'h80000000, 2147483647, 0, 0, 65536, 4));
      send_item(make_particle(5, 5, 2147483647, 32'h80000000, 0, 0, 0, 2));
      drain();
      write_csr(REG_TOP_EN, 32'd0);
      write_csr(REG_WORLD_W, 32'd0);
      send_item(make_particle(10, -100000, 0, 0, 0, 0, 10, 1092));
      send_item(make_particle(10, 5000000, 65536, 65536, 0, 0, 0, 1092));
      drain();
   endtask

   task automatic run_phase(int count);
      repeat (count) begin
         if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
         send_item(random_particle());
      end
      drain();
      no_idle = 0;
   endtask

   task automatic test_defaults_restored;
      write_csr(REG_GRAV_EN, 32'd1);
      write_csr(REG_GRAV_X, 32'd0);
      write_csr(REG_GRAV_Y, 32'd642908);
      write_csr(REG_WORLD_W, 32'd12582912);
      write_csr(REG_WORLD_H, 32'd7077888);
      write_csr(REG_TOP_EN, 32'd1);
      run_phase(70);
   endtask

   task automatic test_gravity_extremes;
      write_csr(REG_GRAV_X, 32'h7FFFFFFF);
      write_csr(REG_GRAV_Y, 32'h80000000);
      run_phase(60);
      write_csr(REG_GRAV_X, 32'h80000000);
      write_csr(REG_GRAV_Y, 32'h7FFFFFFF);
      write_csr(REG_TOP_EN, 32'd0);
      run_phase(60);
   endtask

   task automatic test_world_extremes;
      write_csr(REG_WORLD_W, 32'hFFFFFFFF);
      write_csr(REG_WORLD_H, 32'h7FFFFFFF);
      write_csr(REG_TOP_EN, 32'd1);
      run_phase(60);
      write_csr(REG_WORLD_W, 32'd0);
      write_csr(REG_WORLD_H, 32'd0);
      write_csr(REG_GRAV_EN, 32'd0);
      run_phase(50);
   endtask

   task automatic test_random_config;
      repeat (3) begin
         write_csr(REG_GRAV_EN, $urandom);
         write_csr(REG_GRAV_X, $urandom);
         write_csr(REG_GRAV_Y, $urandom);
         write_csr(REG_WORLD_W, $urandom_range(65536, 20000000));
         write_csr(REG_WORLD_H, $urandom_range(65536, 20000000));
         write_csr(REG_TOP_EN, $urandom);
         run_phase(45);
      end
   endtask

   task automatic test_pause_mid_stream;
      write_csr(REG_GRAV_EN, 32'd1);
      repeat (10) send_item(random_particle());
      drain();
      no_idle = 1;
      repeat (20) send_item(random_particle());
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_defaults_restored();
      test_gravity_extremes();
      test_world_extremes();
      test_random_config();
      test_pause_mid_stream();
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
